### hw/rtl/swdd_pkg.sv
// swdd_pkg: shared types and constants for the split-window drift detector.
// No dependencies; used by swdd_lane, swdd_merge, the core and the testbench.
package swdd_pkg;
    localparam int HISTORY_DEPTH = 512;
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_FIT  = 3'd1;
    localparam logic [2:0] KIND_LOSS = 3'd2;
    localparam logic [2:0] KIND_DOM  = 3'd3;
    localparam logic [2:0] KIND_SUS  = 3'd4;
    localparam logic [16:0] SEV_ONE  = 17'd65536;
    localparam logic [15:0] RUN_MAX  = 16'hFFFF;
    localparam logic [1:0] REG_THR = 2'd0;
    localparam logic [1:0] REG_MIN = 2'd1;
    localparam logic [1:0] REG_SUS = 2'd2;

    // lane control from the sequencer
    typedef struct packed {
        logic clr;   // clear accumulators
        logic acc_b; // add read data to baseline sum
        logic acc_r; // add read data to recent sum
    } t_lane_ctl;
endpackage

### hw/rtl/swdd_div.sv
// swdd_div: restoring signed divider, one quotient bit per cycle.
// Depends on nothing but its ports; truncates toward zero.
module swdd_div #(
    parameter int NW = 64,
    parameter int DW = 13
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic [DW-1:0]        i_den,
    output logic                 o_done,
    output logic signed [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_neg, n_neg, r_busy, n_busy, r_done, n_done;
    logic [DW:0]   w_try;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_neg = r_neg;
        n_busy = r_busy; n_done = 1'b0;
        w_try = {r_rem[DW-1:0], r_q[NW-1]};
        if (i_start) begin
            n_neg  = i_num[NW-1];
            n_q    = i_num[NW-1] ? -i_num : i_num;
            n_rem  = '0;
            n_cnt  = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift in one dividend bit, subtract where it fits
            if (w_try >= {1'b0, i_den}) begin
                n_rem = w_try - {1'b0, i_den};
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = w_try;
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q; r_rem <= n_rem; r_cnt <= n_cnt; r_neg <= n_neg;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

### hw/rtl/swdd_lane.sv
// swdd_lane: one metric's history memory and its two half-window sums.
// Depends on swdd_pkg for the lane control struct.
module swdd_lane #(
    parameter int AW = 9,
    parameter int SW = 45
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [31:0]          i_wdata,
    input  logic [AW-1:0]        i_raddr,
    input  swdd_pkg::t_lane_ctl  i_ctl,
    output logic signed [SW-1:0] o_sum_b,
    output logic signed [SW-1:0] o_sum_r
);
    logic [31:0] r_mem [0:(1<<AW)-1];
    logic [31:0] r_rd;
    logic signed [SW-1:0] r_sum_b, r_sum_r;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rd <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sum_b <= '0;
            r_sum_r <= '0;
        end else begin
            if (i_ctl.acc_b) r_sum_b <= r_sum_b + SW'($signed(r_rd));
            if (i_ctl.acc_r) r_sum_r <= r_sum_r + SW'($signed(r_rd));
        end
    end

    assign o_sum_b = r_sum_b;
    assign o_sum_r = r_sum_r;
endmodule

### hw/rtl/swdd_merge.sv
// swdd_merge: compares the six half-window means and forms the result.
// Depends on swdd_pkg for event codes and limits.
module swdd_merge (
    input  logic signed [31:0] i_bf, i_rf, i_bl, i_rl, i_bd, i_rd,
    input  logic [30:0]        i_thr,
    input  logic [7:0]         i_sus,
    input  logic [15:0]        i_run,
    input  logic [31:0]        i_step,
    output logic [15:0]        o_run,
    output logic [133:0]       o_res
);
    logic signed [33:0] w_df, w_dl, w_dd, w_diff, w_th;
    logic [2:0]  w_kind;
    logic        w_reg, w_deg;
    logic [16:0] w_sev;
    logic [31:0] w_base, w_rec, w_step;

    always_comb begin
        w_df = 34'(i_bf) - 34'(i_rf);
        w_dl = 34'(i_rl) - 34'(i_bl);
        w_dd = 34'(i_bd) - 34'(i_rd);
        w_th = $signed({3'b000, i_thr});
        w_kind = swdd_pkg::KIND_NONE; w_diff = '0; w_base = '0; w_rec = '0;
        if (w_df > w_th) begin
            w_kind = swdd_pkg::KIND_FIT; w_diff = w_df; w_base = i_bf; w_rec = i_rf;
        end else if (w_dl > w_th) begin
            w_kind = swdd_pkg::KIND_LOSS; w_diff = w_dl; w_base = i_bl; w_rec = i_rl;
        end else if (w_dd > w_th) begin
            w_kind = swdd_pkg::KIND_DOM; w_diff = w_dd; w_base = i_bd; w_rec = i_rd;
        end
        w_reg = (w_kind != swdd_pkg::KIND_NONE);
        w_sev = '0; w_step = '0;
        if (w_reg) begin
            w_sev  = (w_diff >= 34'sd32768) ? swdd_pkg::SEV_ONE : 17'(w_diff) << 1;
            w_step = i_step;
            o_run  = (i_run == swdd_pkg::RUN_MAX) ? i_run : i_run + 16'd1;
        end else begin
            o_run  = '0;
        end
        w_deg = (o_run >= {8'd0, i_sus});
        if (w_deg) begin
            w_kind = swdd_pkg::KIND_SUS;
            w_sev  = swdd_pkg::SEV_ONE;
        end
        o_res = {o_run, w_step, w_rec, w_base, w_sev, w_kind, w_deg, w_reg};
    end
endmodule

### hw/rtl/split_window_drift_detector_core.sv
// split_window_drift_detector_core: top level with sequencer, three lanes,
// a shared divider and merge. Depends on swdd_pkg, swdd_lane, swdd_div, swdd_merge.
//
//  channel   dir  tdata fields (low bit up)
//  s_axis    in   fitness, loss, dominance, step (128 bits)
//  m_axis    out  result, 136 bits (see port)
//  apb       in   thr @0, min_samples @4, sustain @8
//
// A compared request sums both half windows (one memory read per cycle per lane),
// runs six divisions through the shared divider and then merges; uncompared
// requests go straight to the output step.
// Reset is synchronous; a result held on m_axis stalls the core only at the
// output step, which holds until the output register is free.
module split_window_drift_detector_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // fitness[31:0], loss[63:32], dominance[95:64], step_number[127:96]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // regression_flag[0], degeneration_flag[1], event_kind[4:2], severity[21:5],
    // baseline_mean[53:22], recent_mean[85:54], event_step[117:86],
    // run_length[133:118], zero fill [135:134]
    output logic [135:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int AW = $clog2(swdd_pkg::HISTORY_DEPTH);
    localparam int CW = $clog2(swdd_pkg::HISTORY_DEPTH + 1);
    localparam int SW = 33 + AW;
    localparam logic [2:0] ST_IDLE = 3'd0, ST_SUM = 3'd1, ST_DIV = 3'd2,
                           ST_OUT = 3'd3;

    logic [30:0] r_thr;
    logic [9:0]  r_min;
    logic [7:0]  r_sus;
    logic [2:0]  r_st;
    logic [CW-1:0] r_fill;
    logic [AW-1:0] r_old;
    logic [15:0] r_run;
    logic [31:0] r_step;
    logic        r_cmp;
    logic [CW-1:0] r_half;
    logic [CW:0]   r_idx;   // read index over 0..2*half-1 (plus drain)
    logic [CW:0]   r_pipe;  // index of data now at accumulator
    logic          r_pv, r_pv2;
    logic [2:0]  r_dsel;
    logic        r_dstart;
    logic signed [31:0] r_mean [0:5];
    logic        r_ov;
    logic [135:0] r_out;
    logic        w_acc, w_we, w_wr_ok, w_cmp, w_out_ld;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [CW-1:0] w_nfill, w_hnext;
    swdd_pkg::t_lane_ctl w_ctl;
    logic signed [SW-1:0] w_sb [0:2];
    logic signed [SW-1:0] w_sr [0:2];
    logic signed [SW-1:0] w_num;
    logic        w_ddone;
    logic signed [SW-1:0] w_quo;
    logic [15:0] w_run;
    logic [133:0] w_res;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3:2])
            swdd_pkg::REG_THR: prdata = {1'b0, r_thr};
            swdd_pkg::REG_MIN: prdata = {22'd0, r_min};
            swdd_pkg::REG_SUS: prdata = {24'd0, r_sus};
            default:           prdata = '0;
        endcase
    end

    assign s_axis_tready = (r_st == ST_IDLE);
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_we  = w_acc;
    assign w_waddr = AW'((CW+1)'(r_old) + (CW+1)'(r_fill));
    assign w_wr_ok = r_fill < CW'(swdd_pkg::HISTORY_DEPTH);
    assign w_nfill = w_wr_ok ? r_fill + 1'b1 : r_fill;
    assign w_hnext = w_nfill >> 1;
    assign w_cmp   = (16'(w_nfill) >= 16'(r_min)) && (w_hnext != '0);
    assign w_out_ld = (r_st == ST_OUT) && (!r_ov || m_axis_tready);
    // second window starts at fill - half
    assign w_raddr = AW'((CW+2)'(r_old) + (CW+2)'(r_idx) +
                         ((r_idx >= (CW+1)'(r_half)) ? (CW+2)'(r_fill - (r_half << 1)) : '0));
    assign w_ctl.clr   = w_acc;
    assign w_ctl.acc_b = r_pv2 && (r_pipe < (CW+1)'(r_half));
    assign w_ctl.acc_r = r_pv2 && (r_pipe >= (CW+1)'(r_half));

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            swdd_lane #(.AW(AW), .SW(SW)) u_lane (
                .i_clk(i_clk), .i_we(w_we),
                .i_waddr(w_wr_ok ? w_waddr : r_old),
                .i_wdata(s_axis_tdata[32*g +: 32]), .i_raddr(w_raddr),
                .i_ctl(w_ctl), .o_sum_b(w_sb[g]), .o_sum_r(w_sr[g]));
        end
    endgenerate

    always_comb begin
        case (r_dsel)
            3'd0: w_num = w_sb[0];
            3'd1: w_num = w_sr[0];
            3'd2: w_num = w_sb[1];
            3'd3: w_num = w_sr[1];
            3'd4: w_num = w_sb[2];
            default: w_num = w_sr[2];
        endcase
    end

    swdd_div #(.NW(SW), .DW(CW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart), .i_num(w_num),
        .i_den(r_half), .o_done(w_ddone), .o_quo(w_quo));

    swdd_merge u_merge (
        .i_bf(r_mean[0]), .i_rf(r_mean[1]), .i_bl(r_mean[2]), .i_rl(r_mean[3]),
        .i_bd(r_mean[4]), .i_rd(r_mean[5]), .i_thr(r_thr), .i_sus(r_sus),
        .i_run(r_run), .i_step(r_step), .o_run(w_run), .o_res(w_res));

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_step <= s_axis_tdata[127:96];
            r_cmp  <= w_cmp;
        end
        if (w_ddone) r_mean[r_dsel] <= 32'(w_quo);
        if (w_out_ld)
            r_out <= r_cmp ? {2'b00, w_res} : {2'b00, r_run, 118'd0};
        r_pipe <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 31'd6554; r_min <= 10'd10; r_sus <= 8'd5;
            r_st <= ST_IDLE; r_fill <= '0; r_old <= '0; r_run <= '0;
            r_ov <= 1'b0; r_pv <= 1'b0; r_pv2 <= 1'b0; r_dstart <= 1'b0;
            r_idx <= '0; r_half <= '0; r_dsel <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    swdd_pkg::REG_THR: r_thr <= pwdata[30:0];
                    swdd_pkg::REG_MIN: r_min <= pwdata[9:0];
                    swdd_pkg::REG_SUS: r_sus <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            r_dstart <= 1'b0;
            r_pv2 <= r_pv;
            unique case (r_st)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_fill <= w_nfill;
                        if (!w_wr_ok) r_old <= AW'((CW+1)'(r_old) + 1'b1);
                        r_half <= w_hnext;
                        r_idx  <= '0;
                        if (w_cmp) begin
                            r_st <= ST_SUM;
                            r_pv <= 1'b1;
                        end else begin
                            r_st <= ST_OUT;
                        end
                    end
                end
                ST_SUM: begin
                    if (r_idx == (CW+1)'({r_half, 1'b0}) - 1'b1) r_pv <= 1'b0;
                    if (r_pv) r_idx <= r_idx + 1'b1;
                    if (!r_pv && !r_pv2) begin
                        r_st <= ST_DIV; r_dsel <= '0; r_dstart <= 1'b1;
                    end
                end
                ST_DIV: begin
                    if (w_ddone) begin
                        if (r_dsel == 3'd5) r_st <= ST_OUT;
                        else begin
                            r_dsel <= r_dsel + 1'b1; r_dstart <= 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (w_out_ld) begin
                        if (r_cmp) r_run <= w_run;
                        r_ov <= 1'b1;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;
endmodule

### tb/testbench.sv
// testbench: self-checking bench for split_window_drift_detector_core.
// Drives sample requests and APB writes, predicts each result in-bench, checks m_axis.
// Depends on swdd_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    localparam int DEPTH = swdd_pkg::HISTORY_DEPTH;
    localparam longint CYCLE_LIMIT = 8000000;

    typedef struct packed {
        logic [31:0] step_number;
        logic [31:0] dominance;
        logic [31:0] loss;
        logic [31:0] fitness;
    } t_sample;

    typedef struct packed {
        logic [1:0]  fill;
        logic [15:0] run_length;
        logic [31:0] event_step;
        logic [31:0] recent_mean;
        logic [31:0] baseline_mean;
        logic [16:0] severity;
        logic [2:0]  event_kind;
        logic        degeneration_flag;
        logic        regression_flag;
    } t_verdict;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // fitness[31:0], loss[63:32], dominance[95:64], step_number[127:96]
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // regression_flag[0], degeneration_flag[1], event_kind[4:2], severity[21:5],
    // baseline_mean[53:22], recent_mean[85:54], event_step[117:86], run_length[133:118]
    logic [135:0] m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    split_window_drift_detector_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [31:0] fit_ring [DEPTH];
    logic [31:0] loss_ring [DEPTH];
    logic [31:0] dom_ring [DEPTH];
    int          ring_fill = 0;
    int          ring_oldest = 0;
    int          drift_run = 0;
    logic [30:0] cfg_threshold = 31'd6554;
    logic [9:0]  cfg_min_samples = 10'd10;
    logic [7:0]  cfg_sustain = 8'd5;

    t_sample     pending_samples[$];
    t_verdict    expected_verdicts[$];
    bit          failed = 1'b0;
    bit          calm = 1'b0;
    bit          hold_arm = 1'b0;
    bit          hold_used = 1'b0;
    int          hold_left = 0;
    bit          s_fire = 1'b0;
    longint      cycles = 0;

    function automatic longint window_mean(ref logic [31:0] ring [DEPTH], input int first,
                                           input int half);
        longint sum;
        sum = 0;
        for (int i = 0; i < half; i++)
            sum += longint'($signed(ring[(ring_oldest + first + i) % DEPTH]));
        return sum / half;
    endfunction

    function automatic t_verdict predict_drift(t_sample smp);
        t_verdict v;
        int half;
        longint bf, rf, bl, rl, bd, rd, diff, sev, th;
        v = '0;
        if (ring_fill < DEPTH) begin
            fit_ring[(ring_oldest + ring_fill) % DEPTH] = smp.fitness;
            loss_ring[(ring_oldest + ring_fill) % DEPTH] = smp.loss;
            dom_ring[(ring_oldest + ring_fill) % DEPTH] = smp.dominance;
            ring_fill++;
        end else begin
            fit_ring[ring_oldest] = smp.fitness;
            loss_ring[ring_oldest] = smp.loss;
            dom_ring[ring_oldest] = smp.dominance;
            ring_oldest = (ring_oldest + 1) % DEPTH;
        end
        half = ring_fill / 2;
        if (ring_fill >= cfg_min_samples && half > 0) begin
            bf = window_mean(fit_ring, 0, half);
            rf = window_mean(fit_ring, ring_fill - half, half);
            bl = window_mean(loss_ring, 0, half);
            rl = window_mean(loss_ring, ring_fill - half, half);
            bd = window_mean(dom_ring, 0, half);
            rd = window_mean(dom_ring, ring_fill - half, half);
            th = longint'(cfg_threshold);
            diff = 0;
            if (bf - rf > th) begin
                v.event_kind = swdd_pkg::KIND_FIT; diff = bf - rf;
                v.baseline_mean = bf[31:0]; v.recent_mean = rf[31:0];
            end else if (rl - bl > th) begin
                v.event_kind = swdd_pkg::KIND_LOSS; diff = rl - bl;
                v.baseline_mean = bl[31:0]; v.recent_mean = rl[31:0];
            end else if (bd - rd > th) begin
                v.event_kind = swdd_pkg::KIND_DOM; diff = bd - rd;
                v.baseline_mean = bd[31:0]; v.recent_mean = rd[31:0];
            end
            if (v.event_kind != swdd_pkg::KIND_NONE) begin
                v.regression_flag = 1'b1;
                sev = (2 * diff > 65536) ? 65536 : 2 * diff;
                v.severity = sev[16:0];
                v.event_step = smp.step_number;
                if (drift_run < 65535) drift_run++;
            end else begin
                drift_run = 0;
            end
            if (drift_run >= cfg_sustain) begin
                v.degeneration_flag = 1'b1;
                v.event_kind = swdd_pkg::KIND_SUS;
                v.severity = swdd_pkg::SEV_ONE;
            end
        end
        v.run_length = drift_run[15:0];
        return v;
    endfunction

    // sender: hold the request until taken, then advance or idle
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || s_fire)) begin
            if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_samples.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off while the sender keeps offering
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_arm && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && (calm || $urandom_range(99) >= 31);
        end
    end

    always @(posedge i_clk) begin
        t_verdict got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            s_fire <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_verdicts.size() == 0) begin
                    $error("result with no request outstanding");
                    failed = 1'b1;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.regression_flag !== want.regression_flag) begin
                        $error("regression_flag exp %0d got %0d",
                               want.regression_flag, got.regression_flag);
                        failed = 1'b1;
                    end
                    if (got.degeneration_flag !== want.degeneration_flag) begin
                        $error("degeneration_flag exp %0d got %0d",
                               want.degeneration_flag, got.degeneration_flag);
                        failed = 1'b1;
                    end
                    if (got.event_kind !== want.event_kind) begin
                        $error("event_kind exp %0d got %0d", want.event_kind, got.event_kind);
                        failed = 1'b1;
                    end
                    if (got.severity !== want.severity) begin
                        $error("severity exp %0d got %0d", want.severity, got.severity);
                        failed = 1'b1;
                    end
                    if (got.baseline_mean !== want.baseline_mean) begin
                        $error("baseline_mean exp %h got %h",
                               want.baseline_mean, got.baseline_mean);
                        failed = 1'b1;
                    end
                    if (got.recent_mean !== want.recent_mean) begin
                        $error("recent_mean exp %h got %h", want.recent_mean, got.recent_mean);
                        failed = 1'b1;
                    end
                    if (got.event_step !== want.event_step) begin
                        $error("event_step exp %h got %h", want.event_step, got.event_step);
                        failed = 1'b1;
                    end
                    if (got.run_length !== want.run_length) begin
                        $error("run_length exp %0d got %0d", want.run_length, got.run_length);
                        failed = 1'b1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_verdicts.push_back(predict_drift(s_axis_tdata));
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() > 0 || s_axis_tvalid || expected_verdicts.size() > 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [30:0] thr, input logic [9:0] min_n,
                              input logic [7:0] sus);
        wait_drained();
        apb_write(swdd_pkg::REG_THR, {1'b0, thr});
        apb_write(swdd_pkg::REG_MIN, {22'd0, min_n});
        apb_write(swdd_pkg::REG_SUS, {24'd0, sus});
        cfg_threshold = thr;
        cfg_min_samples = min_n;
        cfg_sustain = sus;
    endtask

    task automatic push_sample(input logic [31:0] f, input logic [31:0] l,
                               input logic [31:0] d, input logic [31:0] s);
        t_sample smp;
        smp.fitness = f; smp.loss = l; smp.dominance = d; smp.step_number = s;
        pending_samples.push_back(smp);
    endtask

    // trending metrics with noise; occasional full-range outliers
    task automatic push_drift_run(input int count);
        int fit_lvl, loss_lvl, dom_lvl, fit_slope, loss_slope, dom_slope;
        fit_lvl = 0; loss_lvl = 0; dom_lvl = 0;
        fit_slope = 0; loss_slope = 0; dom_slope = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                fit_slope = $urandom_range(8000) - 4000;
                loss_slope = $urandom_range(8000) - 4000;
                dom_slope = $urandom_range(8000) - 4000;
                if ($urandom_range(3) == 0) begin
                    fit_lvl = $urandom_range(2 << 20) - (1 << 20);
                    loss_lvl = $urandom_range(2 << 20) - (1 << 20);
                    dom_lvl = $urandom_range(2 << 20) - (1 << 20);
                end
            end
            fit_lvl += fit_slope; loss_lvl += loss_slope; dom_lvl += dom_slope;
            if ($urandom_range(99) < 8)
                push_sample($urandom, $urandom, $urandom, $urandom);
            else
                push_sample(fit_lvl + $urandom_range(2000) - 1000,
                            loss_lvl + $urandom_range(2000) - 1000,
                            dom_lvl + $urandom_range(2000) - 1000, $urandom);
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, each drift kind, flat reset of the run
        set_config(31'd0, 10'd2, 8'd1);
        push_sample(32'h0, 32'h0, 32'h0, 32'h0);
        push_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
        push_sample(32'h80000000, 32'h80000000, 32'h80000000, 32'h0);
        push_sample(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        push_sample(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555);
        push_sample(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
        for (int i = 0; i < 5; i++)
            push_sample(32'h00100000 - i * 32'h00010000, 32'h0, 32'h0, i);
        for (int i = 0; i < 5; i++)
            push_sample(32'h0, i * 32'h00008000, 32'h0, 100 + i);
        for (int i = 0; i < 4; i++)
            push_sample(32'h0, 32'h0, 32'h00040000 - i * 32'h00001000, 200 + i);
        for (int i = 0; i < 3; i++)
            push_sample(32'h00010000, 32'h00010000, 32'h00010000, 300 + i);

        set_config(31'd6554, 10'd10, 8'd5);
        push_drift_run(250);

        // no compares ever; also exercise the long receiver hold-off
        set_config(31'h7FFFFFFF, 10'd1023, 8'd255);
        hold_arm = 1'b1;
        push_drift_run(60);

        set_config(31'($urandom_range(200000)), 10'd512, 8'd0);
        push_drift_run(150);

        set_config(31'd100, 10'd0, 8'd3);
        calm = 1'b1;
        push_drift_run(120);
        wait_drained();
        calm = 1'b0;
        push_drift_run(180);

        set_config(31'd327680, 10'd300, 8'd255);
        push_drift_run(240);

        wait_drained();
        repeat (50) @(negedge i_clk);
        if (!failed && expected_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
